### rtl/vaos_pkg.sv
// Shared constants, field layout and controller/datapath interface types of the voice allocator.
package vaos_pkg;

    localparam int DEFAULT_VOICES      = 8;
    localparam int DEFAULT_LENGTH_BITS = 24;

    // Input beat layout, from the lowest bit up.
    localparam int ADDR_W      = 32;
    localparam int SND_LEN_W   = 24;
    localparam int TIME_W      = 32;
    localparam int BLK_W       = 16;
    localparam int IN_FIELDS_W = ADDR_W + SND_LEN_W + TIME_W + BLK_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int IN_ADDR_LSB = 0;
    localparam int IN_LEN_LSB  = IN_ADDR_LSB + ADDR_W;
    localparam int IN_TIME_LSB = IN_LEN_LSB + SND_LEN_W;
    localparam int IN_BLK_LSB  = IN_TIME_LSB + TIME_W;

    // Input selector and result kind codes.
    localparam logic MODE_PLAY   = 1'b0;
    localparam logic MODE_BLOCK  = 1'b1;
    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_FETCH  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic play_commit;
        logic walk_step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic any_free;
        logic scan_done;
        logic cur_busy;
        logic walk_done;
        logic out_free;
    } status_t;

endpackage

### rtl/voice_allocator_oldest_steal_unit.sv
// Top level of the voice allocator with oldest-voice stealing.
// Play: a beat with a free voice goes from the scan straight to the emit state, which
// registers its assignment; with every voice busy, the scan first finds the oldest start.
// Throughput: the unit works on one input beat at a time; a block beat walks the voice table
// one voice per cycle while the voice is idle or the output slot is free.
// Reset: rst_n clears all voices to free, the busy count to zero and the output to empty.
module voice_allocator_oldest_steal_unit
#(
    parameter int VOICES      = vaos_pkg::DEFAULT_VOICES,
    parameter int LENGTH_BITS = vaos_pkg::DEFAULT_LENGTH_BITS,
    localparam int VW         = $clog2(VOICES),
    localparam int CW         = $clog2(VOICES + 1),
    localparam int OUT_FIELDS = VW + CW + vaos_pkg::ADDR_W + vaos_pkg::BLK_W + 3,
    localparam int OUT_W      = ((OUT_FIELDS + 7) / 8) * 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: sound_address, sound_length, time_now, block_length.
    input  logic [vaos_pkg::IN_TDATA_W-1:0] s_tdata,
    // Field: mode (0 play a sound, 1 consume one output block).
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: voice, was_stolen, fetch_address, fetch_length, voice_finished,
    // active_count, audio_running, then zero fill.
    output logic [OUT_W-1:0]                m_tdata,
    // Field: result_kind (0 voice assignment, 1 fetch command).
    output logic                            m_tuser,
    output logic                            m_tlast
);

    // The controller decides when to capture, search, commit and walk; the datapath holds
    // the voice tables and a single output register. The output register lets a new beat
    // be accepted while the previous result still waits for m_tready.
    vaos_pkg::cmd_t    cmd;
    vaos_pkg::status_t status;

    vaos_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    vaos_datapath
    #(
        .VOICES      (VOICES),
        .LENGTH_BITS (LENGTH_BITS)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .m_tready (m_tready),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/vaos_ctrl.sv
// Controller state machine that sequences play and block items through the datapath.
module vaos_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tuser,
    input  vaos_pkg::status_t status,
    output logic              s_tready,
    output vaos_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_WALK = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (s_tuser == vaos_pkg::MODE_BLOCK) ? ST_WALK : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // A free voice needs no search; otherwise look for the oldest start time.
                if (status.any_free)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (status.scan_done)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.play_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                // Idle voices are skipped at once; busy ones wait for the output slot.
                if (!status.cur_busy || status.out_free)
                begin
                    cmd.walk_step = 1'b1;
                    if (status.walk_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/vaos_datapath.sv
// Datapath of the voice allocator: voice tables, oldest search, advance logic and output register.
module vaos_datapath
#(
    parameter int VOICES      = vaos_pkg::DEFAULT_VOICES,
    parameter int LENGTH_BITS = vaos_pkg::DEFAULT_LENGTH_BITS,
    localparam int VW         = $clog2(VOICES),
    localparam int CW         = $clog2(VOICES + 1),
    localparam int OUT_FIELDS = VW + CW + vaos_pkg::ADDR_W + vaos_pkg::BLK_W + 3,
    localparam int OUT_W      = ((OUT_FIELDS + 7) / 8) * 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [vaos_pkg::IN_TDATA_W-1:0] s_tdata,
    input  vaos_pkg::cmd_t                  cmd,
    input  logic                            m_tready,
    output vaos_pkg::status_t               status,
    output logic                            m_tvalid,
    output logic [OUT_W-1:0]                m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam logic [VW-1:0] LAST_IDX = VW'(VOICES - 1);

    // Per-voice tables; an entry is only read while its voice is busy.
    logic [vaos_pkg::ADDR_W-1:0] addr_mem  [VOICES];
    logic [LENGTH_BITS-1:0]      left_mem  [VOICES];
    logic [vaos_pkg::TIME_W-1:0] start_mem [VOICES];

    logic [VOICES-1:0]           busy_reg;
    logic [CW-1:0]               total_reg;
    logic [VW-1:0]               idx_reg;
    logic [VW-1:0]               oldest_reg;
    logic [vaos_pkg::TIME_W-1:0] oldest_time_reg;

    logic [vaos_pkg::ADDR_W-1:0]    in_addr_reg;
    logic [vaos_pkg::SND_LEN_W-1:0] in_len_reg;
    logic [vaos_pkg::TIME_W-1:0]    in_time_reg;
    logic [vaos_pkg::BLK_W-1:0]     in_blk_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_kind_reg;
    logic             out_last_reg;

    logic                        free_found;
    logic [VW-1:0]               free_idx;
    logic                        above_busy;
    logic                        cur_busy;
    logic [vaos_pkg::ADDR_W-1:0] cur_addr;
    logic [LENGTH_BITS-1:0]      cur_left;
    logic [vaos_pkg::TIME_W-1:0] cur_time;
    logic [31:0]                 left_ext;
    logic [31:0]                 blk_ext;
    logic [31:0]                 amt_wide;
    logic [vaos_pkg::BLK_W-1:0]  amt;
    logic [LENGTH_BITS-1:0]      left_new;
    logic                        fin;
    logic [31:0]                 snd_len_ext;
    logic [VW-1:0]               sel;
    logic                        stolen;
    logic [CW-1:0]               total_play;
    logic [CW-1:0]               total_walk;
    logic                        out_free;
    logic [OUT_W-1:0]            play_data;
    logic [OUT_W-1:0]            walk_data;

    // Lowest free voice and whether any busy voice sits above the walk position.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        above_busy = 1'b0;
        for (int j = VOICES - 1; j >= 0; j--)
        begin
            if (!busy_reg[j])
            begin
                free_found = 1'b1;
                free_idx   = VW'(j);
            end
            if (busy_reg[j] && (j > int'(idx_reg)))
            begin
                above_busy = 1'b1;
            end
        end
    end

    assign cur_busy = busy_reg[idx_reg];
    assign cur_addr = addr_mem[idx_reg];
    assign cur_left = left_mem[idx_reg];
    assign cur_time = start_mem[idx_reg];

    assign left_ext = 32'(cur_left);
    assign blk_ext  = 32'(in_blk_reg);
    assign amt_wide = (left_ext < blk_ext) ? left_ext : blk_ext;
    assign amt      = amt_wide[vaos_pkg::BLK_W-1:0];
    assign left_new = cur_left - amt_wide[LENGTH_BITS-1:0];
    assign fin      = (left_new == '0);

    assign snd_len_ext = 32'(in_len_reg);

    assign sel        = free_found ? free_idx : oldest_reg;
    assign stolen     = !free_found;
    assign total_play = free_found ? total_reg + CW'(1) : total_reg;
    assign total_walk = fin ? total_reg - CW'(1) : total_reg;

    assign out_free = !out_valid_reg || m_tready;

    assign play_data = OUT_W'({(total_play != '0), total_play, 1'b0, {vaos_pkg::BLK_W{1'b0}},
                               {vaos_pkg::ADDR_W{1'b0}}, stolen, sel});
    assign walk_data = OUT_W'({(total_walk != '0), total_walk, fin, amt, cur_addr, 1'b0,
                               idx_reg});

    assign status.any_free  = free_found;
    assign status.scan_done = (idx_reg == LAST_IDX);
    assign status.cur_busy  = cur_busy;
    assign status.walk_done = !above_busy;
    assign status.out_free  = out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.play_commit || (cmd.walk_step && cur_busy))
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.capture)
            begin
                idx_reg <= '0;
            end
            if (cmd.scan_step || cmd.walk_step)
            begin
                idx_reg <= idx_reg + VW'(1);
            end
            if (cmd.play_commit)
            begin
                busy_reg[sel] <= 1'b1;
                total_reg     <= total_play;
            end
            if (cmd.walk_step && cur_busy && fin)
            begin
                busy_reg[idx_reg] <= 1'b0;
                total_reg         <= total_walk;
            end
        end
    end

    // Payload registers and voice tables.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_addr_reg <= s_tdata[vaos_pkg::IN_ADDR_LSB +: vaos_pkg::ADDR_W];
            in_len_reg  <= s_tdata[vaos_pkg::IN_LEN_LSB +: vaos_pkg::SND_LEN_W];
            in_time_reg <= s_tdata[vaos_pkg::IN_TIME_LSB +: vaos_pkg::TIME_W];
            in_blk_reg  <= s_tdata[vaos_pkg::IN_BLK_LSB +: vaos_pkg::BLK_W];
        end
        if (cmd.scan_step && ((idx_reg == '0) || (cur_time < oldest_time_reg)))
        begin
            oldest_reg      <= idx_reg;
            oldest_time_reg <= cur_time;
        end
        if (cmd.play_commit)
        begin
            addr_mem[sel]  <= in_addr_reg;
            left_mem[sel]  <= snd_len_ext[LENGTH_BITS-1:0];
            start_mem[sel] <= in_time_reg;
            out_data_reg   <= play_data;
            out_kind_reg   <= vaos_pkg::KIND_ASSIGN;
            out_last_reg   <= 1'b1;
        end
        if (cmd.walk_step && cur_busy)
        begin
            addr_mem[idx_reg] <= cur_addr + 32'(amt);
            left_mem[idx_reg] <= left_new;
            out_data_reg      <= walk_data;
            out_kind_reg      <= vaos_pkg::KIND_FETCH;
            out_last_reg      <= !above_busy;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

### rtl/vaos_checker.sv
// Port-level assertions for the voice allocator and the bind that attaches them.
module vaos_checker
#(
    parameter int VOICES      = vaos_pkg::DEFAULT_VOICES,
    localparam int VW         = $clog2(VOICES),
    localparam int CW         = $clog2(VOICES + 1),
    localparam int OUT_FIELDS = VW + CW + vaos_pkg::ADDR_W + vaos_pkg::BLK_W + 3,
    localparam int OUT_W      = ((OUT_FIELDS + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser,
    input logic             m_tlast
);

    localparam int STOLEN_BIT = VW;
    localparam int FADDR_LSB  = VW + 1;
    localparam int FLEN_LSB   = FADDR_LSB + vaos_pkg::ADDR_W;
    localparam int FIN_BIT    = FLEN_LSB + vaos_pkg::BLK_W;
    localparam int COUNT_LSB  = FIN_BIT + 1;
    localparam int RUN_BIT    = COUNT_LSB + CW;

    logic [CW-1:0] count;
    logic          assign_beat;

    assign count       = m_tdata[COUNT_LSB +: CW];
    assign assign_beat = m_tvalid && (m_tuser == vaos_pkg::KIND_ASSIGN);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_running: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[RUN_BIT] == (count != '0)))
        else $error("audio_running disagrees with active_count");

    a_assign_shape: assert property (@(posedge clk) disable iff (!rst_n)
        assign_beat |-> m_tlast && !m_tdata[FIN_BIT] && (count != '0)
                        && (m_tdata[FLEN_LSB +: vaos_pkg::BLK_W] == '0))
        else $error("malformed voice assignment beat");

    a_fetch_live: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == vaos_pkg::KIND_FETCH) && !m_tdata[FIN_BIT]
        |-> (count != '0) && !m_tdata[STOLEN_BIT])
        else $error("unfinished fetch with no busy voice");

endmodule

bind voice_allocator_oldest_steal_unit vaos_checker
#(
    .VOICES (VOICES)
)
u_vaos_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/sv/testbench.sv
// Self-checking testbench for the voice allocator with oldest-voice stealing.
`timescale 1ns / 1ps

module testbench;

    // The unit runs with its default sizes, so the output layout is worked out the same way here.
    localparam int VOICES       = vaos_pkg::DEFAULT_VOICES;
    localparam int VW           = $clog2(VOICES);
    localparam int CW           = $clog2(VOICES + 1);
    localparam int OUT_W        = ((VW + CW + vaos_pkg::ADDR_W + vaos_pkg::BLK_W + 3 + 7) / 8) * 8;
    // Settling time after the last expected beat.
    // The worst case is a full steal search through every voice.
    localparam int DRAIN_CYCLES = 4 * VOICES;

    // One result beat, unpacked into its fields.
    typedef struct packed {
        logic          kind;
        logic [VW-1:0] voice;
        logic          stolen;
        logic [31:0]   addr;
        logic [15:0]   amount;
        logic          finished;
        logic [CW-1:0] active;
        logic          running;
        logic          last;
    } mix_result_t;

    // The scoreboard keeps its own copy of the voice table.
    // For every accepted request beat it predicts the command beats that the unit must emit.
    class voice_scoreboard;
        bit          busy [VOICES];
        bit [31:0]   read_addr [VOICES];
        bit [23:0]   bytes_left [VOICES];
        bit [31:0]   start_tick [VOICES];
        int unsigned busy_count;
        mix_result_t pending_commands [$];
        int unsigned errors;
        int unsigned assigns;
        int unsigned steals;
        int unsigned fetches;
        int unsigned frees;

        function string describe(mix_result_t r);
            return $sformatf(
                "kind=%0d voice=%0d stolen=%0d addr=%h len=%0d fin=%0d active=%0d run=%0d last=%0d",
                r.kind, r.voice, r.stolen, r.addr, r.amount, r.finished, r.active, r.running,
                r.last);
        endfunction

        function void accept_request(logic mode, logic [31:0] addr, logic [23:0] len,
                                     logic [31:0] now, logic [15:0] blk);
            int          sel;
            int          oldest;
            int          last_busy;
            logic [15:0] amt;
            mix_result_t r;
            if (mode == vaos_pkg::MODE_PLAY) begin
                // Take the first free voice. While the scan sees only busy voices, it tracks
                // the oldest one, keeping the lower index on equal start ticks.
                sel = -1;
                oldest = 0;
                for (int i = 0; i < VOICES; i++) begin
                    if (!busy[i]) begin
                        sel = i;
                        break;
                    end
                    if (start_tick[i] < start_tick[oldest])
                        oldest = i;
                end
                r = '0;
                r.kind = vaos_pkg::KIND_ASSIGN;
                if (sel < 0) begin
                    sel = oldest;
                    r.stolen = 1'b1;
                end
                else begin
                    busy_count++;
                end
                busy[sel] = 1'b1;
                read_addr[sel] = addr;
                bytes_left[sel] = len;
                start_tick[sel] = now;
                r.voice = sel[VW-1:0];
                r.active = busy_count[CW-1:0];
                r.running = (busy_count != 0);
                r.last = 1'b1;
                pending_commands.push_back(r);
            end
            else begin
                // Walk the busy voices in index order. A block with no busy voice emits nothing.
                last_busy = -1;
                for (int i = 0; i < VOICES; i++)
                    if (busy[i])
                        last_busy = i;
                for (int i = 0; i < VOICES; i++) begin
                    if (busy[i]) begin
                        amt = (bytes_left[i] < {8'd0, blk}) ? bytes_left[i][15:0] : blk;
                        r = '0;
                        r.kind = vaos_pkg::KIND_FETCH;
                        r.voice = i[VW-1:0];
                        r.addr = read_addr[i];
                        r.amount = amt;
                        read_addr[i] = read_addr[i] + amt;
                        bytes_left[i] = bytes_left[i] - amt;
                        if (bytes_left[i] == 0) begin
                            busy[i] = 1'b0;
                            if (busy_count > 0)
                                busy_count--;
                            r.finished = 1'b1;
                        end
                        r.active = busy_count[CW-1:0];
                        r.running = (busy_count != 0);
                        r.last = (i == last_busy);
                        pending_commands.push_back(r);
                    end
                end
            end
        endfunction

        function void check_command(logic [OUT_W-1:0] data, logic kind, logic last);
            mix_result_t got;
            mix_result_t want;
            got.kind = kind;
            got.voice = data[VW-1:0];
            got.stolen = data[VW];
            got.addr = data[VW+1 +: 32];
            got.amount = data[VW+33 +: 16];
            got.finished = data[VW+49];
            got.active = data[VW+50 +: CW];
            got.running = data[VW+50+CW];
            got.last = last;
            if (pending_commands.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected beat: %s", $realtime, describe(got));
                return;
            end
            want = pending_commands.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("[%0t] mismatch", $realtime);
                    $display("    expected %s", describe(want));
                    $display("    actual   %s", describe(got));
                end
            end
            if (want.kind == vaos_pkg::KIND_ASSIGN) begin
                assigns++;
                if (want.stolen)
                    steals++;
            end
            else begin
                fetches++;
                if (want.finished)
                    frees++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // Fields from bit 0: sound_address, sound_length, time_now, block_length.
    logic [vaos_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    // Field: mode.
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // Fields from bit 0: voice, was_stolen, fetch_address, fetch_length, voice_finished,
    // active_count, audio_running, then zero fill.
    logic [OUT_W-1:0]                m_tdata;
    // Field: result_kind.
    logic                            m_tuser;
    logic                            m_tlast;

    // Random gaps and stalls are only allowed while this is set.
    // The last part of the run clears it, so that the unit also sees back-to-back traffic.
    logic                            idling = 1'b1;
    int                              stall_left = 0;
    logic [31:0]                     tick = 32'd1000;
    voice_scoreboard                 board = new();

    always #5 clk = ~clk;

    voice_allocator_oldest_steal_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Drives one request beat and holds it until the unit takes it.
    // The scoreboard hears about the beat at the edge where it is accepted.
    // When no gap is inserted, tvalid simply stays high into the next beat.
    task automatic send_request(logic mode, logic [31:0] addr, logic [23:0] len,
                                logic [31:0] now, logic [15:0] blk);
        int gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {blk, now, len, addr};
        do
            @(posedge clk);
        while (!s_tready);
        board.accept_request(mode, addr, len, now, blk);
    endtask

    // Fields that a beat does not use carry random noise, because the unit must ignore them.
    task automatic play(logic [31:0] addr, logic [23:0] len, logic [31:0] now);
        send_request(vaos_pkg::MODE_PLAY, addr, len, now, 16'($urandom));
    endtask

    task automatic mix_block(logic [15:0] blk);
        send_request(vaos_pkg::MODE_BLOCK, $urandom, 24'($urandom), $urandom, blk);
    endtask

    // The receiver side checks each accepted command beat.
    // Its tready is dropped in random bursts while idling is set.
    // Every value is read as it stood before the edge.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            board.check_command(m_tdata, m_tuser, m_tlast);
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idling && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end
        else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        int pick;
        logic [31:0] start;
        logic [23:0] len;
        logic [15:0] blk;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A block with no busy voice produces nothing.
        // Next comes a zero-length sound, which the following block fetches as length 0
        // and then frees.
        mix_block(16'd100);
        play(32'hFFFF_FFF0, 24'd0, 32'd5);
        mix_block(16'hFFFF);

        // Fill all eight voices. Three of them share the smallest start tick, 50.
        // The voices also cover the widest length, an address that wraps,
        // and the largest start tick.
        play(32'h0000_1000, 24'd300, 32'd100);
        play(32'hFFFF_FFFF, 24'hFF_FFFF, 32'd50);
        play(32'h8000_0000, 24'd64, 32'd50);
        play(32'hFFFF_FF00, 24'h00_0100, 32'd200);
        play(32'h1234_5678, 24'd1, 32'd300);
        play(32'h0000_0000, 24'h80_0000, 32'hFFFF_FFFF);
        play(32'hAAAA_AAAA, 24'd7, 32'd50);
        play(32'h5555_5555, 24'd1000, 32'd500);

        // Stealing starts here.
        // On the tie at tick 50 the lowest index loses its voice.
        // That voice now holds tick 0, so it is taken again and gets a zero-length sound.
        // The third steal falls on the next tie at tick 50.
        play(32'hDEAD_0000, 24'd40, 32'd0);
        play(32'h0000_00FF, 24'd0, 32'd60);
        play(32'h4000_0000, 24'd12, 32'd50);

        // A zero-length block frees only the voice that was already empty.
        // A new sound then takes that voice again, as the lowest free one.
        // Full, one-byte and small blocks follow.
        mix_block(16'd0);
        play(32'h0BAD_F00D, 24'd20, 32'd10);
        mix_block(16'hFFFF);
        mix_block(16'd1);
        mix_block(16'd5);

        // The random part mixes plays and blocks with mostly short sounds.
        // Voices therefore come and go, while full-width values still reach every bit.
        // Start ticks mostly climb, and often repeat so that ties appear.
        // Now and then a tick is fully random.
        for (int n = 0; n < 100; n++) begin
            if (n == 75)
                idling <= 1'b0;
            if ($urandom_range(0, 99) < 55) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    tick = tick + $urandom_range(0, 40);
                    start = tick;
                end
                else if (pick < 8) begin
                    start = tick;
                end
                else begin
                    start = $urandom;
                end
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    len = 24'($urandom);
                else if (pick == 1)
                    len = 24'd0;
                else
                    len = 24'($urandom_range(1, 1500));
                play($urandom, len, start);
            end
            else begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    blk = 16'($urandom);
                else if (pick == 1)
                    blk = 16'd0;
                else
                    blk = 16'($urandom_range(1, 600));
                mix_block(blk);
            end
        end
        s_tvalid <= 1'b0;

        // Wait for every predicted beat to arrive.
        // The extra cycles after that let a late stray beat show up.
        while (board.pending_commands.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d voice assignments (%0d of them took over the oldest voice)",
                 board.assigns, board.steals);
        $display("and %0d fetch commands (%0d of them freed their voice); %0d errors.",
                 board.fetches, board.frees, board.errors);
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // The run needs well under 100 us.
    // This guard stops a hung handshake.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
rtl/vaos_pkg.sv
rtl/vaos_ctrl.sv
rtl/vaos_datapath.sv
rtl/voice_allocator_oldest_steal_unit.sv
rtl/vaos_checker.sv
tb/sv/testbench.sv
